### rtl/fhcp_pkg.sv
// Package for the framed hex command parser: framing bytes, command
// characters, result kind codes, the result record and the hex digit decoder.
// No dependencies.
`default_nettype none

package fhcp_pkg;

  localparam logic [7:0] BYTE_START = 8'h01;
  localparam logic [7:0] BYTE_END   = 8'h04;

  localparam logic [7:0] CH_LPAREN = 8'h28;  // '('
  localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] CH_ONE    = 8'h31;  // '1'
  localparam logic [7:0] CH_DOT    = 8'h2E;  // '.'
  localparam logic [7:0] CH_THREE  = 8'h33;  // '3'
  localparam logic [7:0] CH_UPPER_F = 8'h46; // 'F'
  localparam logic [7:0] CH_SPACE  = 8'h20;  // ' '
  localparam logic [7:0] CH_NINE   = 8'h39;  // '9'
  localparam logic [7:0] CH_UPPER_A = 8'h41; // 'A'
  localparam logic [7:0] CH_LOWER_A = 8'h61; // 'a'
  localparam logic [7:0] CH_LOWER_F = 8'h66; // 'f'

  localparam logic [7:0] COUNT_MAX = 8'hFF;
  localparam logic [7:0] LEN_SHORT_CMD = 8'd3;
  localparam logic [7:0] LEN_TELEGRAM_MIN = 8'd2;
  localparam logic [7:0] LEN_TELEGRAM_LONG = 8'd9;

  typedef enum logic [1:0] {
    KIND_PING     = 2'd0,
    KIND_INFO     = 2'd1,
    KIND_TELEGRAM = 2'd2,
    KIND_UNKNOWN  = 2'd3
  } frame_kind_t;

  typedef struct packed {
    frame_kind_t  kind;
    logic [31:0]  value;
    logic         is_long;
    logic [7:0]   length;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] digit;
  } hex_dec_t;

  // Decodes one ASCII hex digit; ok is low for any other byte.
  function automatic hex_dec_t hex_decode(input logic [7:0] c);
    hex_dec_t   r;
    logic [7:0] d;
    r = '{ok: 1'b0, digit: 4'd0};
    d = 8'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
      r.ok = 1'b1;
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
      d = c - CH_UPPER_A + 8'd10;
      r.ok = 1'b1;
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
      d = c - CH_LOWER_A + 8'd10;
      r.ok = 1'b1;
    end
    r.digit = d[3:0];
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/fhcp_frame.sv
// Frame state of the parser: byte count, first three characters and the
// running hex value, with the end-of-frame classification.
// Depends on fhcp_pkg.
`default_nettype none

module fhcp_frame (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire logic [7:0]       rx_byte,
  output fhcp_pkg::result_t     result
);
  import fhcp_pkg::*;

  logic [7:0]  byte_count;
  logic [7:0]  head_chars [3];
  logic [31:0] hex_accumulator;
  logic        hex_stopped;

  logic        is_start;
  logic        is_end;
  hex_dec_t    dec;

  assign is_start = (rx_byte == BYTE_START);
  assign is_end   = (rx_byte == BYTE_END);
  assign dec      = hex_decode(rx_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      head_chars[0]   <= '0;
      head_chars[1]   <= '0;
      head_chars[2]   <= '0;
      hex_accumulator <= '0;
      hex_stopped     <= 1'b0;
    end else if (step) begin
      if (is_start || is_end) begin
        byte_count      <= '0;
        head_chars[0]   <= '0;
        head_chars[1]   <= '0;
        head_chars[2]   <= '0;
        hex_accumulator <= '0;
        hex_stopped     <= 1'b0;
      end else begin
        if (byte_count < LEN_SHORT_CMD) begin
          head_chars[byte_count[1:0]] <= rx_byte;
        end
        // The first character is the frame marker; digits start after it.
        if (byte_count != 8'd0 && !hex_stopped) begin
          if (dec.ok) begin
            hex_accumulator <= {hex_accumulator[27:0], dec.digit};
          end else begin
            hex_stopped <= 1'b1;
          end
        end
        if (byte_count != COUNT_MAX) begin
          byte_count <= byte_count + 8'd1;
        end
      end
    end
  end

  always_comb begin
    result.kind    = KIND_UNKNOWN;
    result.value   = '0;
    result.is_long = 1'b0;
    result.length  = byte_count;
    if (byte_count == LEN_SHORT_CMD && head_chars[0] == CH_LPAREN &&
        head_chars[1] == CH_ZERO && head_chars[2] == CH_ONE) begin
      result.kind = KIND_PING;
    end else if (byte_count == LEN_SHORT_CMD && head_chars[0] == CH_DOT &&
                 head_chars[1] == CH_THREE && head_chars[2] == CH_UPPER_F) begin
      result.kind = KIND_INFO;
    end else if (byte_count >= LEN_TELEGRAM_MIN && head_chars[0] == CH_SPACE) begin
      result.kind    = KIND_TELEGRAM;
      result.value   = hex_accumulator;
      result.is_long = (byte_count == LEN_TELEGRAM_LONG);
    end
  end

  a_clear_on_start: assert property (@(posedge clk) disable iff (rst)
    step && is_start |=> byte_count == 8'd0 && hex_accumulator == 32'd0 && !hex_stopped)
    else $error("frame state not cleared by start byte");

  a_count_advances: assert property (@(posedge clk) disable iff (rst)
    step && !is_start && !is_end && byte_count != COUNT_MAX
      |=> byte_count == $past(byte_count) + 8'd1)
    else $error("byte count did not advance on a data byte");

  a_stop_after_marker: assert property (@(posedge clk) disable iff (rst)
    hex_stopped |-> byte_count >= LEN_TELEGRAM_MIN)
    else $error("hex scan stopped before any digit position");

  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(byte_count) && $stable(hex_accumulator))
    else $error("frame state changed without a byte");

endmodule

`default_nettype wire

### rtl/framed_hex_command_parser_core.sv
// Top level of the framed hex command parser: input register, frame state
// and the result register. Depends on fhcp_pkg and fhcp_frame.
`default_nettype none

//  Channel  Direction  Handshake                 Payload
//  in       to core    in_valid / in_stall       rx_byte
//  out      from core  out_valid / out_stall     frame_kind, telegram_value,
//                                                telegram_long, frame_length
//
// One byte is taken every cycle while in_stall is low. An accepted byte sits in
// the input register and is applied to the frame state from there; an end
// byte's result is loaded into the output register as the end byte is applied,
// and is held there until it is taken with out_stall low.
// A result that waits in the output register only holds back an end byte;
// data and start bytes keep flowing under out_stall.
// Reset (rst, synchronous) empties both registers and clears the frame.
module framed_hex_command_parser_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       frame_kind,
  output logic [31:0]      telegram_value,
  output logic             telegram_long,
  output logic [7:0]       frame_length
);
  import fhcp_pkg::*;

  // Input register.
  logic       s1_valid;
  logic [7:0] s1_byte;

  logic       s1_is_end;
  logic       out_free;
  logic       s1_move;
  result_t    frame_result;

  assign s1_is_end = (s1_byte == BYTE_END);
  // The output register can take a result when empty or being drained.
  assign out_free  = !out_valid || !out_stall;
  // A held byte goes to the frame state unless it is an end byte that
  // would have to overwrite a result still waiting.
  assign s1_move   = s1_valid && (!s1_is_end || out_free);
  assign in_stall  = s1_valid && !s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte <= rx_byte;
    end
  end

  fhcp_frame u_frame (
    .clk     (clk),
    .rst     (rst),
    .step    (s1_move),
    .rx_byte (s1_byte),
    .result  (frame_result)
  );

  // Result register: loaded when an end byte is applied.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move && s1_is_end) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_is_end) begin
      frame_kind     <= frame_result.kind;
      telegram_value <= frame_result.value;
      telegram_long  <= frame_result.is_long;
      frame_length   <= frame_result.length;
    end
  end

endmodule

`default_nettype wire

### bench/framed_hex_command_parser_core_tb.sv
// Self-checking bench for framed_hex_command_parser_core: byte stream stimulus,
// a frame classifier that runs alongside the block, and checks on each result.
// Depends on fhcp_pkg and the core RTL.
`timescale 1ns / 100ps

module framed_hex_command_parser_core_tb;
  import fhcp_pkg::*;

  // Follows the frame state byte by byte and queues the result that each end
  // byte must produce. Results from the block are matched in order.
  class frame_tracker;
    logic [7:0]  byte_count;
    logic [7:0]  head_chars [3];
    logic [31:0] hex_acc;
    bit          hex_stopped;
    result_t     pending_frames[$];
    int          error_count;

    function new();
      error_count = 0;
      clear();
    endfunction

    function void clear();
      byte_count = 8'd0;
      head_chars[0] = 8'd0;
      head_chars[1] = 8'd0;
      head_chars[2] = 8'd0;
      hex_acc = 32'd0;
      hex_stopped = 1'b0;
    endfunction

    // Bit 4 set means the byte is a hex digit; bits 3:0 hold its value.
    // Letters of both cases have 1..6 in the low nibble.
    function logic [4:0] hex_value(logic [7:0] b);
      if (b >= CH_ZERO && b <= CH_NINE) return {1'b1, b[3:0]};
      if ((b >= CH_UPPER_A && b <= CH_UPPER_F) || (b >= CH_LOWER_A && b <= CH_LOWER_F))
        return {1'b1, b[3:0] + 4'd9};
      return 5'd0;
    endfunction

    function void take_byte(logic [7:0] b);
      result_t     r;
      logic [4:0]  nib;
      if (b == BYTE_START) begin
        clear();
      end else if (b == BYTE_END) begin
        r.kind = KIND_UNKNOWN;
        r.value = 32'd0;
        r.is_long = 1'b0;
        r.length = byte_count;
        if (byte_count == LEN_SHORT_CMD && head_chars[0] == CH_LPAREN &&
            head_chars[1] == CH_ZERO && head_chars[2] == CH_ONE) begin
          r.kind = KIND_PING;
        end else if (byte_count == LEN_SHORT_CMD && head_chars[0] == CH_DOT &&
                     head_chars[1] == CH_THREE && head_chars[2] == CH_UPPER_F) begin
          r.kind = KIND_INFO;
        end else if (byte_count >= LEN_TELEGRAM_MIN && head_chars[0] == CH_SPACE) begin
          r.kind = KIND_TELEGRAM;
          r.value = hex_acc;
          r.is_long = (byte_count == LEN_TELEGRAM_LONG);
        end
        pending_frames = {pending_frames, r};
        clear();
      end else begin
        if (byte_count < 8'd3) head_chars[byte_count] = b;
        if (byte_count != 8'd0 && !hex_stopped) begin
          nib = hex_value(b);
          if (nib[4]) hex_acc = {hex_acc[27:0], nib[3:0]};
          else hex_stopped = 1'b1;
        end
        if (byte_count != COUNT_MAX) byte_count = byte_count + 8'd1;
      end
    endfunction

    function bit field_ok(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void check_frame(logic [1:0] kind, logic [31:0] value, logic is_long,
                              logic [7:0] length);
      result_t r;
      bit      ok;
      if (pending_frames.size() == 0) begin
        $display("%0t: unexpected result, expected none actual kind %0d length %0d",
                 $time, kind, length);
        error_count++;
        return;
      end
      r = pending_frames.pop_front();
      ok = field_ok("frame_kind", 32'(r.kind), 32'(kind));
      ok = field_ok("telegram_value", r.value, value) && ok;
      ok = field_ok("telegram_long", 32'(r.is_long), 32'(is_long)) && ok;
      ok = field_ok("frame_length", 32'(r.length), 32'(length)) && ok;
      if (!ok) error_count++;
    endfunction

    function void flag_leftovers();
      foreach (pending_frames[i])
        $display("%0t: missing result, expected kind %0d length %0d actual none",
                 $time, pending_frames[i].kind, pending_frames[i].length);
      error_count += pending_frames.size();
    endfunction
  endclass

  // Everything the block sees starts at a known value.
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  frame_kind;
  logic [31:0] telegram_value;
  logic        telegram_long;
  logic [7:0]  frame_length;

  frame_tracker tracker;
  logic [7:0]   frame_buf[$];  // bytes of the frame being assembled for sending
  int           bytes_sent;
  int           frames_seen;
  bit           steady_send;   // sender offers back to back while set
  bit           calm_recv;     // receiver starts no new random stall while set
  bit           hold_done;
  int           hold_left;
  int           stall_left;
  int           drain_cycles;

  framed_hex_command_parser_core uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .frame_kind(frame_kind),
    .telegram_value(telegram_value),
    .telegram_long(telegram_long),
    .frame_length(frame_length)
  );

  always #1 clk = ~clk;

  // Gap before the next byte: none while steady_send is set, else mostly none, sometimes short, rarely long.
  function automatic int pick_gap();
    int r;
    if (steady_send) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offers one byte and waits for its transaction. Valid is only dropped when
  // a gap is wanted, so it never toggles twice in one time step. All sampling
  // happens at the rising edge, before the block's registers update.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (in_stall);
    tracker.take_byte(b);
    bytes_sent++;
  endtask

  task automatic flush_frame();
    foreach (frame_buf[i]) send_byte(frame_buf[i]);
    frame_buf.delete();
  endtask

  // Adds one byte at the tail of the frame being assembled.
  task automatic append_byte(input logic [7:0] b);
    frame_buf = {frame_buf, b};
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) append_byte(s[i]);
  endtask

  // Any byte that neither clears nor ends a frame.
  function automatic logic [7:0] data_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == BYTE_START || b == BYTE_END);
    return b;
  endfunction

  // A hex digit in either letter case.
  function automatic logic [7:0] hex_char();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return CH_ZERO + 8'(r);
    if (r < 16) return CH_UPPER_A + 8'(r - 10);
    return CH_LOWER_A + 8'(r - 16);
  endfunction

  // Telegram body: a space, then hex digits with an occasional stray byte that
  // can stop accumulation. The random frame task makes eight characters common.
  task automatic push_telegram(input int n);
    int stray_at;
    stray_at = ($urandom_range(0, 99) < 30) ? $urandom_range(0, n) : -1;
    append_byte(CH_SPACE);
    for (int i = 0; i < n; i++)
      append_byte((i == stray_at) ? data_byte() : hex_char());
  endtask

  // A frame that can run past the saturation point of the length counter.
  task automatic push_oversized();
    append_byte(CH_SPACE);
    repeat ($urandom_range(250, 270))
      append_byte(($urandom_range(0, 9) == 0) ? data_byte() : hex_char());
  endtask

  // One random frame, mostly well formed, sometimes damaged or pure noise.
  task automatic send_random_frame();
    int  r;
    bit  with_end;
    with_end = 1'b1;
    if ($urandom_range(0, 1) == 1) append_byte(BYTE_START);
    r = $urandom_range(0, 99);
    if (r < 8) begin
      push_text("(01");
    end else if (r < 16) begin
      push_text(".3F");
    end else if (r < 26) begin
      // Near miss of a short command: one character changed, or one too few
      // or too many.
      push_text(($urandom_range(0, 1) == 1) ? "(01" : ".3F");
      case ($urandom_range(0, 2))
        0: frame_buf[$urandom_range(0, 2)] = data_byte();
        1: void'(frame_buf.pop_back());
        default: append_byte(data_byte());
      endcase
    end else if (r < 58) begin
      push_telegram(($urandom_range(0, 2) == 0) ? 8 : $urandom_range(0, 12));
    end else if (r < 68) begin
      push_telegram($urandom_range(9, 20));
    end else if (r < 78) begin
      repeat ($urandom_range(0, 10)) append_byte(data_byte());
    end else if (r < 88) begin
      // A partial frame abandoned by a clear, then a good one.
      repeat ($urandom_range(1, 6)) append_byte(data_byte());
      append_byte(BYTE_START);
      push_telegram($urandom_range(1, 9));
    end else if (r < 99) begin
      // Raw noise: any byte value, framing bytes included, no forced end.
      repeat ($urandom_range(1, 8)) append_byte(8'($urandom_range(0, 255)));
      with_end = 1'b0;
    end else begin
      push_oversized();
    end
    if (with_end) append_byte(BYTE_END);
    flush_frame();
  endtask

  // Receiver: checks each result transaction and decides the next stall.
  // After a few dozen results it holds off for a long stretch so the block
  // backs up and stalls its input while the sender keeps offering bytes.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        tracker.check_frame(frame_kind, telegram_value, telegram_long, frame_length);
        frames_seen++;
      end
      if (!hold_done && frames_seen == 40) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if ($urandom_range(0, 199) == 0) calm_recv = !calm_recv;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (calm_recv || $urandom_range(0, 99) < 75) begin
        out_stall <= 1'b0;
      end else begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
                                                   $urandom_range(0, 2);
        out_stall <= 1'b1;
      end
    end
  end

  // Main sequence: reset, directed frames, random frames, drain, verdict.
  initial begin
    tracker = new();
    bytes_sent = 0;
    frames_seen = 0;
    steady_send = 1'b0;
    calm_recv = 1'b0;
    hold_done = 1'b0;
    hold_left = 0;
    stall_left = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: an end with nothing collected, both short commands, a lone
    // space, a long telegram mixing letter cases, a telegram stopped by the
    // top byte, and a clear in the middle of a frame.
    append_byte(BYTE_END);
    push_text("(01");
    append_byte(BYTE_END);
    push_text(".3F");
    append_byte(BYTE_END);
    push_text(" ");
    append_byte(BYTE_END);
    push_text(" 89abcDEF");
    append_byte(BYTE_END);
    push_text(" ");
    append_byte(8'hFF);
    append_byte(8'h00);
    append_byte(BYTE_END);
    push_text("(0");
    append_byte(BYTE_START);
    push_text(".3F");
    append_byte(BYTE_END);
    flush_frame();

    // One oversized frame up front, then random frames until the byte
    // budget is spent. Some frames go out without any idling.
    push_oversized();
    append_byte(BYTE_END);
    flush_frame();
    while (bytes_sent < 1550) begin
      steady_send = ($urandom_range(0, 4) == 0);
      send_random_frame();
    end
    in_valid <= 1'b0;

    // Drain the expected results, then wait for strays before the verdict.
    drain_cycles = 0;
    while (tracker.pending_frames.size() != 0 && drain_cycles < 5000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (10) @(posedge clk);
    tracker.flag_leftovers();
    if (tracker.error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
